// ===== hdl/f2d96_pkg.sv =====
// ----------------------------------------------------------------------------
// f2d96_pkg: constants for the binary32 to 96-bit decimal converter
// Holds the magnitude limits and the divide-by-ten reciprocal.
// ----------------------------------------------------------------------------
package f2d96_pkg;

    localparam int MANT_W   = 96;
    localparam int SCALE_W  = 5;
    localparam int CHUNK_W  = 16;
    localparam int NCHUNK   = MANT_W / CHUNK_W;

    localparam logic [MANT_W-1:0]  BIG_LIMIT   = MANT_W'(10000000);
    localparam logic [MANT_W-1:0]  SMALL_LIMIT = MANT_W'(1000000);
    localparam logic [23:0]        LOW_MANT    = 24'd16615350;
    localparam logic [SCALE_W-1:0] MAX_SCALE   = 5'd28;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SH for x below 2**22
    localparam logic [19:0] RECIP10  = 20'd838861;
    localparam int          RECIP_SH = 23;

    localparam logic [7:0] EXP_BIAS_INT = 8'd150;
    localparam logic [7:0] EXP_MIN      = 8'd33;
    localparam logic [7:0] EXP_MAX      = 8'd223;

endpackage

// ===== hdl/float32_to_decimal96.sv =====
// ----------------------------------------------------------------------------
// float32_to_decimal96: binary32 to 96-bit decimal converter
// Sequence: zero, failing and whole inputs of 2^23 up to 1e7 go straight to the
//   result; other small inputs scale by five (up to 28 steps), round, then
//   strip zeros by trial divides; large inputs divide by ten (up to 22 times),
//   round once and multiply back by ten. The divide-by-ten unit takes one
//   16-bit chunk per cycle.
// Throughput: one request at a time; a new request is taken only in idle,
//   after the result is accepted. Reset (sync, active low) idles the block.
// ----------------------------------------------------------------------------
module float32_to_decimal96 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // float_bits[31:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // mant_low[63:0], mant_high[95:64], scale[100:96], negative[101],
    // failed[102], zero fill[103]
    output logic [103:0] o_m_tdata
);
    import f2d96_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOOP, S_SRND, S_STRIP, S_LDIV, S_DIV, S_DIVEND, S_LMUL, S_OUT
    } t_state;

    t_state               r_state;
    logic [MANT_W-1:0]    r_acc;
    logic [MANT_W-1:0]    r_save;
    logic [3:0]           r_rem;
    logic [2:0]           r_cnt;
    logic [6:0]           r_kk;
    logic [4:0]           r_k;
    logic [4:0]           r_tz;
    logic [SCALE_W-1:0]   r_scale;
    logic                 r_neg;
    logic                 r_fail;
    logic                 r_sticky;
    logic [3:0]           r_dig;
    logic                 r_strip;

    // input decode
    logic [7:0]        ex;
    logic [22:0]       frac;
    logic [23:0]       mant;
    logic [MANT_W-1:0] v_big;
    logic [4:0]        tz;

    assign ex   = i_s_tdata[30:23];
    assign frac = i_s_tdata[22:0];
    assign mant = {1'b1, frac};
    assign v_big = {{(MANT_W-24){1'b0}}, mant} << 7'(ex - EXP_BIAS_INT);

    always_comb begin
        tz = 5'd23;
        for (int i = 22; i >= 0; i--) begin
            if (mant[i]) begin
                tz = 5'(i);
            end
        end
    end

    // shared right shifter
    logic [6:0]        sh_amt;
    logic [MANT_W-1:0] shr;
    assign sh_amt = (r_state == S_SRND) ? (r_kk - 7'd1) : r_kk;
    assign shr    = r_acc >> sh_amt;

    // divide-by-ten unit: one 16-bit chunk per cycle, most significant first
    logic [19:0]       cur;
    logic [39:0]       prod;
    logic [15:0]       dq;
    logic [19:0]       drem;
    assign cur  = {r_rem, r_acc[MANT_W-1 -: CHUNK_W]};
    assign prod = {20'd0, cur} * {20'd0, RECIP10};
    assign dq   = prod[RECIP_SH+15:RECIP_SH];
    assign drem = cur - 20'({4'd0, dq} * 20'd10);

    // any dropped digit, the latest one included, makes an exact limit too big
    logic big_more;
    assign big_more = (r_acc > BIG_LIMIT)
                      || ((r_acc == BIG_LIMIT) && (r_sticky || r_dig != 4'd0));

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {1'b0, r_fail, r_neg, r_scale, r_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_neg    <= i_s_tdata[31];
                        r_fail   <= 1'b0;
                        r_scale  <= '0;
                        r_tz     <= tz;
                        r_sticky <= 1'b0;
                        r_dig    <= '0;
                        r_k      <= '0;
                        r_rem    <= '0;
                        if (ex == 8'd0 && frac == 23'd0) begin
                            r_acc   <= '0;
                            r_state <= S_OUT;
                        end else if (ex >= EXP_MAX || ex < EXP_MIN
                                     || (ex == EXP_MIN && mant < LOW_MANT)) begin
                            r_acc   <= '0;
                            r_neg   <= 1'b0;
                            r_fail  <= 1'b1;
                            r_state <= S_OUT;
                        end else if (ex >= EXP_BIAS_INT) begin
                            r_acc   <= v_big;
                            r_state <= (v_big > BIG_LIMIT) ? S_LDIV : S_OUT;
                        end else begin
                            r_acc   <= {{(MANT_W-24){1'b0}}, mant};
                            r_kk    <= 7'(EXP_BIAS_INT - ex);
                            r_state <= S_SLOOP;
                        end
                    end
                end
                S_SLOOP: begin
                    if (r_scale == MAX_SCALE || r_kk == 7'd0
                        || {2'd0, r_tz} >= r_kk || shr >= SMALL_LIMIT) begin
                        r_state <= S_SRND;
                    end else begin
                        r_acc   <= (r_acc << 2) + r_acc;
                        r_kk    <= r_kk - 7'd1;
                        r_scale <= r_scale + 5'd1;
                    end
                end
                S_SRND: begin
                    // round half away from zero on the first dropped bit
                    if (r_kk == 7'd0) begin
                        r_acc <= {32'd0, r_acc[63:0]};
                    end else begin
                        r_acc <= {32'd0, shr[64:1] + {63'd0, shr[0]}};
                    end
                    r_state <= S_STRIP;
                end
                S_STRIP: begin
                    if (r_scale != '0 && r_acc != '0) begin
                        r_save  <= r_acc;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_strip <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_LDIV: begin
                    if (big_more) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_strip <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_acc   <= r_acc + MANT_W'(r_dig >= 4'd5);
                        r_state <= S_LMUL;
                    end
                end
                S_DIV: begin
                    r_acc <= {r_acc[MANT_W-CHUNK_W-1:0], dq};
                    r_rem <= drem[3:0];
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'(NCHUNK - 1)) begin
                        r_state <= S_DIVEND;
                    end
                end
                S_DIVEND: begin
                    if (r_strip) begin
                        if (r_rem == 4'd0) begin
                            r_scale <= r_scale - 5'd1;
                            r_state <= S_STRIP;
                        end else begin
                            r_acc   <= r_save;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_sticky <= r_sticky | (r_dig != 4'd0);
                        r_dig    <= r_rem;
                        r_k      <= r_k + 5'd1;
                        r_state  <= S_LDIV;
                    end
                end
                S_LMUL: begin
                    if (r_k != '0) begin
                        r_acc <= (r_acc << 3) + (r_acc << 1);
                        r_k   <= r_k - 5'd1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
